/* rtl/core/dvp_pkg.sv */
// Shared types and character constants for the dotted version parser.
package dvp_pkg;

	localparam logic [15:0] CH_DOT  = 16'h002E;
	localparam logic [15:0] CH_ZERO = 16'h0030;
	localparam logic [15:0] CH_NINE = 16'h0039;

	localparam logic [1:0] LAST_PART = 2'd2;

	// Parse state carried from one character to the next
	typedef struct packed {
		logic [1:0]  part_index;
		logic [31:0] accumulator;
		logic        part_has_digit;
		logic        error_seen;
		logic [31:0] stored_major;
		logic [31:0] stored_minor;
	} dvp_state_t;

	// One parse result
	typedef struct packed {
		logic        valid_res;
		logic [31:0] major_number;
		logic [31:0] minor_number;
		logic [31:0] build_number;
	} dvp_result_t;

endpackage

/* rtl/core/dvp_step.sv */
// Per-character parse step: next state and the result it would give.
module dvp_step
	import dvp_pkg::*;
(
	input  dvp_state_t  cur,
	input  logic [15:0] char_code,
	output dvp_state_t  nxt,
	output dvp_result_t res
);

	logic        is_dot;
	logic        is_digit;
	logic [3:0]  digit;
	logic [35:0] acc_wide;
	logic [35:0] times_ten;
	logic        ok;

	// Classify the character
	assign is_dot   = (char_code == CH_DOT);
	assign is_digit = (char_code inside {[CH_ZERO:CH_NINE]});
	assign digit    = char_code[3:0];

	// Multiply by ten as two shifts and add the digit; top bits flag overflow
	assign acc_wide  = {4'b0000, cur.accumulator};
	assign times_ten = (acc_wide << 3) + (acc_wide << 1) + {32'd0, digit};

	// Advance the parse state
	always_comb begin
		nxt = cur;
		if (is_dot) begin
			if (cur.part_index == LAST_PART || !cur.part_has_digit) begin
				nxt.error_seen = 1'b1;
			end else begin
				if (cur.part_index == 2'd0) begin
					nxt.stored_major = cur.accumulator;
				end else begin
					nxt.stored_minor = cur.accumulator;
				end
				nxt.part_index     = cur.part_index + 2'd1;
				nxt.accumulator    = 32'd0;
				nxt.part_has_digit = 1'b0;
			end
		end else if (is_digit) begin
			if (times_ten[35:32] != 4'd0) begin
				nxt.error_seen = 1'b1;
			end else begin
				nxt.accumulator    = times_ten[31:0];
				nxt.part_has_digit = 1'b1;
			end
		end else begin
			nxt.error_seen = 1'b1;
		end
	end

	// Form the result; zero the numbers when the string is malformed
	assign ok = !nxt.error_seen && (nxt.part_index == LAST_PART) && nxt.part_has_digit;

	always_comb begin
		res.valid_res    = ok;
		res.major_number = ok ? nxt.stored_major : 32'd0;
		res.minor_number = ok ? nxt.stored_minor : 32'd0;
		res.build_number = ok ? nxt.accumulator  : 32'd0;
	end

endmodule

/* rtl/core/dotted_version_parser.sv */
// Top level of the dotted version parser: input stage, parse state, result register.
// A final character is staged in the input register, then its result is registered.
// Throughput: one character per cycle; the parse step is a single add-and-compare stage.
// A full result register that is stalled holds back only a final character.
// Reset (arst_n low, asynchronous) clears the parse state and both valid flags.
module dotted_version_parser
	import dvp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        char_valid,
	output logic        char_stall,
	input  logic [15:0] char_code,
	input  logic        end_of_string,
	output logic        res_valid,
	input  logic        res_stall,
	output logic        valid_res,
	output logic [31:0] major_number,
	output logic [31:0] minor_number,
	output logic [31:0] build_number
);

	logic        vld_s1;
	logic [15:0] char_s1;
	logic        eos_s1;

	dvp_state_t  state_q;
	dvp_state_t  state_nxt;
	dvp_result_t step_res;
	dvp_result_t res_q;
	logic        res_valid_q;

	logic        res_free;
	logic        proc;

	dvp_step u_step (
		.cur       (state_q),
		.char_code (char_s1),
		.nxt       (state_nxt),
		.res       (step_res)
	);

	// Process the staged character unless it is final and the result slot is busy
	assign res_free   = !res_valid_q || !res_stall;
	assign proc       = vld_s1 && (!eos_s1 || res_free);
	assign char_stall = vld_s1 && !proc;

	// Input stage: load on transfer, drop when processed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (char_valid && !char_stall) begin
			vld_s1 <= 1'b1;
		end else if (proc) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (char_valid && !char_stall) begin
			char_s1 <= char_code;
			eos_s1  <= end_of_string;
		end
	end

	// Parse state: advance per character, clear after the final one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (proc) begin
			state_q <= eos_s1 ? dvp_state_t'('0) : state_nxt;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (proc && eos_s1) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proc && eos_s1) begin
			res_q <= step_res;
		end
	end

	assign res_valid    = res_valid_q;
	assign valid_res    = res_q.valid_res;
	assign major_number = res_q.major_number;
	assign minor_number = res_q.minor_number;
	assign build_number = res_q.build_number;

	// Dot count never passes the last part
	a_part_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.part_index != 2'd3)
		else $error("part index out of range");

	// A final character leaves the parse state cleared
	a_clear_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		proc && eos_s1 |=> state_q == dvp_state_t'('0))
		else $error("parse state not cleared after final character");

	// A malformed string reports all numbers as zero
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !valid_res |->
			major_number == 32'd0 && minor_number == 32'd0 && build_number == 32'd0)
		else $error("invalid result carries nonzero numbers");

	// Input stalls only behind a final character waiting on a busy result slot
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		char_stall |-> vld_s1 && eos_s1 && res_valid && res_stall)
		else $error("input stalled without a blocked result");

endmodule
